### design/sllc_pkg.sv
package sllc_pkg;

  // Field widths
  localparam int unsigned RegW      = 16;
  localparam int unsigned ThrW      = 10;
  localparam int unsigned RawW      = 8;
  localparam int unsigned AgeW      = 8;
  localparam int unsigned RatioW    = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned DwellFrac = 7;

  // Limits are disabled until the ignition has been on this many ticks
  localparam logic [AgeW-1:0] IgnMinAge = 8'd20;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_ON        = 2'd1,
    MODE_UNLIMITED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    AFR_NORMAL = 2'd0,
    AFR_LAUNCH = 2'd1,
    AFR_SHIFT  = 2'd2
  } afr_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAUNCH_REV_LIMIT = 3'd0,
    REG_SHIFT_REV_LIMIT  = 3'd1,
    REG_SHIFT_TARGET_AFR = 3'd2,
    REG_CUT_HOLDOFF      = 3'd3,
    REG_ACTIVE_START     = 3'd4,
    REG_THROTTLE_LOW     = 3'd5,
    REG_THROTTLE_HIGH    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [RatioW-1:0] dwell_ratio;
    logic [RegW-1:0]   shaft_period;
    logic              decay_tick;
    logic              vehicle_moving;
    logic [AgeW-1:0]   ignition_age;
    logic              rpm_high;
    logic [RawW-1:0]   throttle_raw;
    logic              clutch_pressed;
  } req_t;

  typedef struct packed {
    logic [RegW-1:0] afr_value;
    afr_sel_e        afr_select;
    logic [RegW-1:0] dwell_max;
    logic [RegW-1:0] rev_limit;
    logic            spark_cut;
    mode_e           mode;
  } res_t;

endpackage

### design/shift_launch_limiter_control.sv
// Launch limiter and no-lift-shift limiter control, one request per control tick.
// Each request (clutch, throttle, rpm-high, ignition age, movement, decay tick,
// shaft period, dwell ratio) steps the off/on/unlimited mode machine, the
// throttle-high hysteresis flag, the active counter and the spark cut flag, and
// yields one result: mode, spark cut, rev limit, dwell maximum, AFR select and AFR value.
// Timing: a request is registered on acceptance, evaluated in the next cycle
// by one short combinational pass (a 16x8 multiply and a few compares), and
// the result lands in an output register once that register is free. One
// request per cycle is sustained while the result side does not stall, and a
// stalled result register still lets the input register take one more request.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write them only while the block is idle, which the block does not enforce; indexes beyond the list are ignored.
module shift_launch_limiter_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side: clutch_pressed[0], throttle_raw[8:1], rpm_high[9],
  // ignition_age[17:10], vehicle_moving[18], decay_tick[19],
  // shaft_period[35:20], dwell_ratio[43:36], zero fill [47:44]
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [sllc_pkg::InDataW-1:0]        s_axis_tdata_i,
  // master side: mode[1:0], spark_cut[2], rev_limit[18:3], dwell_max[34:19],
  // afr_select[36:35], afr_value[52:37], zero fill [55:53]
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [sllc_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [sllc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sllc_pkg::RegW-1:0]           cfg_data_i
);
  import sllc_pkg::*;

  localparam int unsigned ReqW  = $bits(req_t);
  localparam int unsigned ResW  = $bits(res_t);
  localparam int unsigned ProdW = RegW + RatioW;

  // configuration
  logic [RegW-1:0] launch_rev_limit_q, shift_rev_limit_q, shift_target_afr_q;
  logic [RegW-1:0] cut_holdoff_q, active_start_q;
  logic [ThrW-1:0] thr_low_q, thr_high_q;

  // controller state
  mode_e           mode_q, mode_d;
  logic [RegW-1:0] act_cnt_q, act_cnt_d;
  logic            thr_flag_q, thr_flag_d;
  logic            clutch_prev_q;
  logic            cut_q, cut_d;

  // pipeline
  logic  in_vld_q;
  req_t  in_q;
  logic  out_vld_q;
  res_t  out_q, res_d;
  logic  out_free, advance;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_rev_limit_q <= '0;
      shift_rev_limit_q  <= '0;
      shift_target_afr_q <= '0;
      cut_holdoff_q      <= '0;
      active_start_q     <= '0;
      thr_low_q          <= '0;
      thr_high_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAUNCH_REV_LIMIT: launch_rev_limit_q <= cfg_data_i;
        REG_SHIFT_REV_LIMIT:  shift_rev_limit_q  <= cfg_data_i;
        REG_SHIFT_TARGET_AFR: shift_target_afr_q <= cfg_data_i;
        REG_CUT_HOLDOFF:      cut_holdoff_q      <= cfg_data_i;
        REG_ACTIVE_START:     active_start_q     <= cfg_data_i;
        REG_THROTTLE_LOW:     thr_low_q          <= cfg_data_i[ThrW-1:0];
        REG_THROTTLE_HIGH:    thr_high_q         <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= req_t'(s_axis_tdata_i[ReqW-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // One tick of the controller
  // ---------------------------------------------------------------------------
  logic [ThrW-1:0]  throttle;
  logic [RegW-1:0]  cnt_dec, bound;
  logic             press, release_edge, launch;
  logic [ProdW-1:0] prod;
  logic [ProdW-DwellFrac-1:0] dwell_full;

  always_comb begin
    throttle = {in_q.throttle_raw, 2'b00};

    // decay first, saturating at zero
    cnt_dec = (in_q.decay_tick && act_cnt_q != '0) ? act_cnt_q - 1'b1 : act_cnt_q;

    // hysteresis; set wins when thresholds cross
    if (throttle >= thr_high_q) begin
      thr_flag_d = 1'b1;
    end else if (throttle < thr_low_q) begin
      thr_flag_d = 1'b0;
    end else begin
      thr_flag_d = thr_flag_q;
    end

    press        = in_q.clutch_pressed && !clutch_prev_q;
    release_edge = !in_q.clutch_pressed && clutch_prev_q;

    mode_d    = mode_q;
    act_cnt_d = cnt_dec;
    if (press) begin
      if (thr_flag_d && in_q.rpm_high) begin
        mode_d    = MODE_ON;
        act_cnt_d = active_start_q;
      end else begin
        mode_d = MODE_UNLIMITED;
      end
    end else if (release_edge) begin
      mode_d = MODE_OFF;
    end

    // expiry or throttle drop
    if (mode_d == MODE_ON && (act_cnt_d == '0 || !thr_flag_d)) begin
      mode_d = MODE_UNLIMITED;
    end

    bound = (active_start_q > cut_holdoff_q) ? active_start_q - cut_holdoff_q : '0;
    if (mode_d != MODE_ON) begin
      act_cnt_d = '0;
      cut_d     = 1'b0;
    end else begin
      cut_d = act_cnt_d < bound;
    end

    launch = !in_q.vehicle_moving && in_q.clutch_pressed;

    res_d.mode      = mode_d;
    res_d.spark_cut = cut_d;

    res_d.rev_limit = '0;
    if (in_q.ignition_age >= IgnMinAge) begin
      if (launch) begin
        res_d.rev_limit = launch_rev_limit_q;
      end else if (cut_d) begin
        res_d.rev_limit = shift_rev_limit_q;
      end
    end

    prod       = in_q.shaft_period * in_q.dwell_ratio;
    dwell_full = prod[ProdW-1:DwellFrac];
    if (in_q.shaft_period < res_d.rev_limit) begin
      res_d.dwell_max = '0;
    end else if (dwell_full[ProdW-DwellFrac-1:RegW] != '0) begin
      res_d.dwell_max = '1;
    end else begin
      res_d.dwell_max = dwell_full[RegW-1:0];
    end

    // launch map is looked up outside, so its value field stays zero
    if (launch) begin
      res_d.afr_select = AFR_LAUNCH;
      res_d.afr_value  = '0;
    end else if (cut_d) begin
      res_d.afr_select = AFR_SHIFT;
      res_d.afr_value  = shift_target_afr_q;
    end else begin
      res_d.afr_select = AFR_NORMAL;
      res_d.afr_value  = '0;
    end
  end

  // state commits only when the tick moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_OFF;
      act_cnt_q     <= '0;
      thr_flag_q    <= 1'b0;
      clutch_prev_q <= 1'b0;
      cut_q         <= 1'b0;
    end else if (advance) begin
      mode_q        <= mode_d;
      act_cnt_q     <= act_cnt_d;
      thr_flag_q    <= thr_flag_d;
      clutch_prev_q <= in_q.clutch_pressed;
      cut_q         <= cut_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-ResW){1'b0}}, out_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // spark cut flag only lives in the on mode
  a_cut_only_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cut_q |-> mode_q == MODE_ON)
    else $error("spark cut set outside on mode");

  // active counter is cleared whenever the mode is not on
  a_cnt_only_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_cnt_q != '0) |-> mode_q == MODE_ON)
    else $error("active counter nonzero outside on mode");

  // shift AFR override in a result implies spark cut in the same result
  a_afr_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.afr_select == AFR_SHIFT) |-> out_q.spark_cut)
    else $error("shift AFR select without spark cut");

  // state moves only with an advancing tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(act_cnt_q))
    else $error("controller state changed without a tick");

endmodule
